// ----- rtl/lcmlt_pkg.sv -----
// Shared constants, types and state codes of the minimum line tree.
`timescale 1ns / 1ps
`default_nettype none
package lcmlt_pkg;

  localparam int POINTS    = 1024;
  localparam int TREE_N    = 1024;
  localparam int NODES     = 2 * TREE_N - 1;
  localparam int IDX_W     = 10;
  localparam int NODE_W    = 11;
  localparam int SPAN_W    = 11;
  localparam int WALK_W    = 12;
  localparam int COORD_W   = 31;
  localparam int SLOPE_W   = 31;
  localparam int ICPT_W    = 32;
  localparam int PROD_W    = 62;
  localparam int VAL_W     = 64;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 31'sd1073741823;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_ADD   = 2'd1,
    FN_QUERY = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_CHK,
    ST_A_LEFT,
    ST_A_SHIFT,
    ST_D_NREQ,
    ST_D_NCHK,
    ST_D_CREQ,
    ST_D_MULA,
    ST_D_ADDA,
    ST_D_MULP,
    ST_D_CMP,
    ST_D_DEC,
    ST_Q_CREQ,
    ST_Q_XLAT,
    ST_Q_NREQ,
    ST_Q_NCHK,
    ST_Q_MUL,
    ST_Q_ADD,
    ST_Q_NEXT,
    ST_Q_DONE
  } state_e;

  typedef struct packed {
    logic                      valid;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
  } node_t;

  typedef struct packed {
    logic                      mul_en;
    logic signed [SLOPE_W-1:0] a;
    logic signed [COORD_W-1:0] x;
    logic signed [ICPT_W-1:0]  b;
  } lu_req_t;

endpackage
`default_nettype wire

// ----- rtl/lcmlt_chan_if.sv -----
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps
`default_nettype none
interface lcmlt_in_if;
  logic                                       valid;
  logic                                       ready;
  logic [1:0]                                 func;
  logic [lcmlt_pkg::IDX_W-1:0]                point_index;
  logic signed [lcmlt_pkg::COORD_W-1:0]       coordinate;
  logic signed [lcmlt_pkg::SLOPE_W-1:0]       slope;
  logic signed [lcmlt_pkg::ICPT_W-1:0]        intercept;
  logic [lcmlt_pkg::IDX_W-1:0]                range_first;
  logic [lcmlt_pkg::SPAN_W-1:0]               range_end;

  modport source (output valid, func, point_index, coordinate, slope, intercept,
                  range_first, range_end, input ready);
  modport sink (input valid, func, point_index, coordinate, slope, intercept,
                range_first, range_end, output ready);
endinterface

interface lcmlt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lcmlt_pkg::VAL_W-1:0]   min_value;
  logic                                 no_line;

  modport source (output valid, min_value, no_line, input ready);
  modport sink (input valid, min_value, no_line, output ready);
endinterface
`default_nettype wire

// ----- rtl/li_chao_min_line_tree.sv -----
// Top level of the minimum line tree: sequencer, coordinate and node stores.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block runs a clearing pass (one node and one coordinate a
// cycle) and takes no item meanwhile. A load is written to the coordinate store
// as it is taken. A query reads the point's coordinate, then walks from its leaf
// up over the 11 tree levels and evaluates the line at each level that holds one.
// An add visits at most two nodes a level of the range split; each node's descent
// runs three point evaluations at every level where the node holds a line, with
// one shared 31x31 multiplier doing every slope*x product.
// Items are taken one at a time; a finished result waits in the output register.
module li_chao_min_line_tree (
  input  wire            clk_i,
  input  wire            rst_ni,
  lcmlt_in_if.sink       in_i,
  lcmlt_out_if.source    out_o
);

  localparam int NW = lcmlt_pkg::NODE_W;
  localparam int SW = lcmlt_pkg::SPAN_W;
  localparam int WW = lcmlt_pkg::WALK_W;
  localparam int IW = lcmlt_pkg::IDX_W;

  lcmlt_pkg::state_e state_q, state_d;

  // stores
  lcmlt_pkg::node_t                     node_mem [lcmlt_pkg::TREE_N*2];
  logic signed [lcmlt_pkg::COORD_W-1:0] coord_mem [lcmlt_pkg::TREE_N];
  lcmlt_pkg::node_t                     node_rd_q;
  logic signed [lcmlt_pkg::COORD_W-1:0] coord_rd_q;

  logic                                 node_we;
  logic [NW-1:0]                        node_waddr, node_raddr;
  lcmlt_pkg::node_t                     node_wdata;
  logic                                 coord_we;
  logic [IW-1:0]                        coord_waddr, coord_raddr;
  logic signed [lcmlt_pkg::COORD_W-1:0] coord_wdata;

  // working registers
  logic [NW-1:0]                        clr_q;
  logic [IW-1:0]                        idx_q;
  logic signed [lcmlt_pkg::SLOPE_W-1:0] slope_q, a_q, pk_q;
  logic signed [lcmlt_pkg::ICPT_W-1:0]  icpt_q, b_q, qk_q;
  logic signed [lcmlt_pkg::COORD_W-1:0] x_q;
  logic [WW-1:0]                        l0_q, r0_q, sz_q;
  logic [SW-1:0]                        s0_q, t0_q, l_q, r_q;
  logic [NW-1:0]                        k_q;
  logic                                 ret_left_q;
  logic [1:0]                           pt_q;
  logic [2:0]                           bits_q;
  logic signed [lcmlt_pkg::VAL_W-1:0]   va_q, best_q;
  logic                                 found_q;
  logic                                 out_valid_q;
  logic signed [lcmlt_pkg::VAL_W-1:0]   out_min_q;
  logic                                 out_nol_q;

  logic                                 accept;
  logic [SW-1:0]                        end_clamp;
  logic [SW-1:0]                        mid;
  logic signed [lcmlt_pkg::VAL_W-1:0]   sum;
  lcmlt_pkg::lu_req_t                   lu_req;
  logic                                 lb, mb, rb, go_left;
  logic [NW-1:0]                        k_next;
  logic [SW-1:0]                        l_next, r_next;

  assign accept    = in_i.valid && in_i.ready;
  assign end_clamp = (in_i.range_end > SW'(lcmlt_pkg::POINTS)) ? SW'(lcmlt_pkg::POINTS)
                                                               : in_i.range_end;
  assign mid       = SW'(({1'b0, l_q} + {1'b0, r_q}) >> 1);
  assign lb        = bits_q[0];
  assign mb        = bits_q[1];
  assign rb        = bits_q[2];
  assign go_left   = (lb != mb);
  assign k_next    = go_left ? NW'({k_q, 1'b0} + 12'd1) : NW'({k_q, 1'b0} + 12'd2);
  assign l_next    = go_left ? l_q : mid;
  assign r_next    = go_left ? mid : r_q;

  lcmlt_line_unit u_unit (
    .clk_i (clk_i),
    .req_i (lu_req),
    .sum_o (sum)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcmlt_pkg::ST_CLEAR: begin
        if (clr_q == NW'(2 * lcmlt_pkg::TREE_N - 1)) state_d = lcmlt_pkg::ST_IDLE;
      end
      lcmlt_pkg::ST_IDLE: begin
        if (accept) begin
          case (lcmlt_pkg::func_e'(in_i.func))
            lcmlt_pkg::FN_ADD: begin
              if ({1'b0, in_i.range_first} < end_clamp) state_d = lcmlt_pkg::ST_A_CHK;
            end
            lcmlt_pkg::FN_QUERY: state_d = lcmlt_pkg::ST_Q_CREQ;
            default:             state_d = lcmlt_pkg::ST_IDLE;
          endcase
        end
      end
      lcmlt_pkg::ST_A_CHK: begin
        if (l0_q < r0_q) state_d = r0_q[0] ? lcmlt_pkg::ST_D_NREQ : lcmlt_pkg::ST_A_LEFT;
        else             state_d = lcmlt_pkg::ST_IDLE;
      end
      lcmlt_pkg::ST_A_LEFT:  state_d = l0_q[0] ? lcmlt_pkg::ST_D_NREQ : lcmlt_pkg::ST_A_SHIFT;
      lcmlt_pkg::ST_A_SHIFT: state_d = lcmlt_pkg::ST_A_CHK;
      lcmlt_pkg::ST_D_NREQ:  state_d = lcmlt_pkg::ST_D_NCHK;
      lcmlt_pkg::ST_D_NCHK: begin
        if (!node_rd_q.valid) state_d = ret_left_q ? lcmlt_pkg::ST_A_SHIFT : lcmlt_pkg::ST_A_LEFT;
        else                  state_d = lcmlt_pkg::ST_D_CREQ;
      end
      lcmlt_pkg::ST_D_CREQ: state_d = lcmlt_pkg::ST_D_MULA;
      lcmlt_pkg::ST_D_MULA: state_d = lcmlt_pkg::ST_D_ADDA;
      lcmlt_pkg::ST_D_ADDA: state_d = lcmlt_pkg::ST_D_MULP;
      lcmlt_pkg::ST_D_MULP: state_d = lcmlt_pkg::ST_D_CMP;
      lcmlt_pkg::ST_D_CMP:  state_d = (pt_q == 2'd2) ? lcmlt_pkg::ST_D_DEC : lcmlt_pkg::ST_D_CREQ;
      lcmlt_pkg::ST_D_DEC: begin
        if ((lb == rb) || (r_next <= l_next))
          state_d = ret_left_q ? lcmlt_pkg::ST_A_SHIFT : lcmlt_pkg::ST_A_LEFT;
        else
          state_d = lcmlt_pkg::ST_D_NREQ;
      end
      lcmlt_pkg::ST_Q_CREQ: state_d = lcmlt_pkg::ST_Q_XLAT;
      lcmlt_pkg::ST_Q_XLAT: state_d = lcmlt_pkg::ST_Q_NREQ;
      lcmlt_pkg::ST_Q_NREQ: state_d = lcmlt_pkg::ST_Q_NCHK;
      lcmlt_pkg::ST_Q_NCHK: state_d = node_rd_q.valid ? lcmlt_pkg::ST_Q_MUL : lcmlt_pkg::ST_Q_NEXT;
      lcmlt_pkg::ST_Q_MUL:  state_d = lcmlt_pkg::ST_Q_ADD;
      lcmlt_pkg::ST_Q_ADD:  state_d = lcmlt_pkg::ST_Q_NEXT;
      lcmlt_pkg::ST_Q_NEXT: state_d = (k_q == '0) ? lcmlt_pkg::ST_Q_DONE : lcmlt_pkg::ST_Q_NREQ;
      lcmlt_pkg::ST_Q_DONE: if (!out_valid_q) state_d = lcmlt_pkg::ST_IDLE;
      default:              state_d = lcmlt_pkg::ST_CLEAR;
    endcase
  end

  // outputs: store ports and the shared unit
  always_comb begin
    node_we     = 1'b0;
    node_waddr  = k_q;
    node_wdata  = '{valid: 1'b1, slope: a_q, intercept: b_q};
    node_raddr  = k_q;
    coord_we    = 1'b0;
    coord_waddr = in_i.point_index;
    coord_wdata = in_i.coordinate;
    coord_raddr = idx_q;
    lu_req      = '{mul_en: 1'b0, a: a_q, x: coord_rd_q, b: b_q};
    in_i.ready  = (state_q == lcmlt_pkg::ST_IDLE);
    case (state_q)
      lcmlt_pkg::ST_CLEAR: begin
        node_we     = 1'b1;
        node_waddr  = clr_q;
        node_wdata  = '0;
        coord_we    = 1'b1;
        coord_waddr = clr_q[IW-1:0];
        coord_wdata = lcmlt_pkg::COORD_MAX;
      end
      lcmlt_pkg::ST_IDLE: begin
        coord_we = accept && (in_i.func == lcmlt_pkg::FN_LOAD);
      end
      lcmlt_pkg::ST_D_NCHK: node_we = !node_rd_q.valid;
      lcmlt_pkg::ST_D_CREQ: begin
        case (pt_q)
          2'd0:    coord_raddr = l_q[IW-1:0];
          2'd1:    coord_raddr = mid[IW-1:0];
          default: coord_raddr = IW'(r_q - SW'(1));
        endcase
      end
      lcmlt_pkg::ST_D_MULA: lu_req.mul_en = 1'b1;
      lcmlt_pkg::ST_D_MULP: lu_req = '{mul_en: 1'b1, a: pk_q, x: x_q, b: qk_q};
      lcmlt_pkg::ST_D_CMP:  lu_req.b = qk_q;
      lcmlt_pkg::ST_D_DEC:  node_we = (lb && rb) || (!(lb == rb) && mb);
      lcmlt_pkg::ST_Q_MUL:  lu_req = '{mul_en: 1'b1, a: pk_q, x: x_q, b: qk_q};
      lcmlt_pkg::ST_Q_ADD:  lu_req.b = qk_q;
      default: ;
    endcase
  end

  // stores
  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (coord_we) coord_mem[coord_waddr] <= coord_wdata;
    coord_rd_q <= coord_mem[coord_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcmlt_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lcmlt_pkg::ST_CLEAR) clr_q <= clr_q + NW'(1);
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      else if (state_q == lcmlt_pkg::ST_Q_DONE && !out_valid_q) out_valid_q <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      lcmlt_pkg::ST_IDLE: begin
        idx_q   <= in_i.point_index;
        slope_q <= in_i.slope;
        icpt_q  <= in_i.intercept;
        l0_q    <= WW'(in_i.range_first) + WW'(lcmlt_pkg::TREE_N);
        r0_q    <= WW'(end_clamp) + WW'(lcmlt_pkg::TREE_N);
        s0_q    <= SW'(in_i.range_first);
        t0_q    <= end_clamp;
        sz_q    <= WW'(1);
      end
      lcmlt_pkg::ST_A_CHK: begin
        if (l0_q < r0_q && r0_q[0]) begin
          r0_q       <= r0_q - WW'(1);
          t0_q       <= t0_q - sz_q[SW-1:0];
          k_q        <= NW'(r0_q - WW'(2));
          l_q        <= t0_q - sz_q[SW-1:0];
          r_q        <= t0_q;
          a_q        <= slope_q;
          b_q        <= icpt_q;
          ret_left_q <= 1'b0;
        end
      end
      lcmlt_pkg::ST_A_LEFT: begin
        if (l0_q[0]) begin
          k_q        <= NW'(l0_q - WW'(1));
          l_q        <= s0_q;
          r_q        <= s0_q + sz_q[SW-1:0];
          l0_q       <= l0_q + WW'(1);
          s0_q       <= s0_q + sz_q[SW-1:0];
          a_q        <= slope_q;
          b_q        <= icpt_q;
          ret_left_q <= 1'b1;
        end
      end
      lcmlt_pkg::ST_A_SHIFT: begin
        l0_q <= l0_q >> 1;
        r0_q <= r0_q >> 1;
        sz_q <= sz_q << 1;
      end
      lcmlt_pkg::ST_D_NCHK: begin
        pk_q <= node_rd_q.slope;
        qk_q <= node_rd_q.intercept;
        pt_q <= 2'd0;
      end
      lcmlt_pkg::ST_D_MULA: x_q  <= coord_rd_q;
      lcmlt_pkg::ST_D_ADDA: va_q <= sum;
      lcmlt_pkg::ST_D_CMP: begin
        bits_q[pt_q] <= (va_q < sum);
        pt_q         <= pt_q + 2'd1;
      end
      lcmlt_pkg::ST_D_DEC: begin
        // the line lower at the middle stays; the loser walks on
        if (mb) begin
          a_q <= pk_q;
          b_q <= qk_q;
        end
        k_q <= k_next;
        l_q <= l_next;
        r_q <= r_next;
      end
      lcmlt_pkg::ST_Q_XLAT: begin
        x_q     <= coord_rd_q;
        k_q     <= NW'(idx_q) + NW'(lcmlt_pkg::TREE_N - 1);
        found_q <= 1'b0;
      end
      lcmlt_pkg::ST_Q_NCHK: begin
        pk_q <= node_rd_q.slope;
        qk_q <= node_rd_q.intercept;
      end
      lcmlt_pkg::ST_Q_ADD: begin
        if (!found_q || sum < best_q) best_q <= sum;
        found_q <= 1'b1;
      end
      lcmlt_pkg::ST_Q_NEXT: k_q <= (k_q - NW'(1)) >> 1;
      lcmlt_pkg::ST_Q_DONE: begin
        if (!out_valid_q) begin
          out_min_q <= found_q ? best_q : '0;
          out_nol_q <= !found_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.min_value = out_min_q;
  assign out_o.no_line   = out_nol_q;

  // a result only appears at the end of a query walk
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lcmlt_pkg::ST_Q_DONE))
    else $error("result raised outside query completion");

  // node store is never written while idle
  a_no_idle_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcmlt_pkg::ST_IDLE) |-> !node_we)
    else $error("node write while idle");

  // descent stays inside the tree
  a_node_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcmlt_pkg::ST_D_NREQ) |-> (k_q < NW'(lcmlt_pkg::NODES)))
    else $error("node index beyond tree");

  // a query finishing with a pending result waits for the transfer
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcmlt_pkg::ST_Q_DONE && out_valid_q && !out_o.ready)
      |=> (state_q == lcmlt_pkg::ST_Q_DONE))
    else $error("query result overrun");

endmodule
`default_nettype wire

// ----- rtl/lcmlt_line_unit.sv -----
// Shared line evaluator: registered slope*x product, then add of the intercept.
`timescale 1ns / 1ps
`default_nettype none
module lcmlt_line_unit (
  input  wire                                   clk_i,
  input  wire lcmlt_pkg::lu_req_t               req_i,
  output logic signed [lcmlt_pkg::VAL_W-1:0]    sum_o
);

  logic signed [lcmlt_pkg::PROD_W-1:0] prod_q, prod_d;

  assign prod_d = req_i.a * req_i.x;

  always_ff @(posedge clk_i) begin
    if (req_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign sum_o = {{(lcmlt_pkg::VAL_W-lcmlt_pkg::PROD_W){prod_q[lcmlt_pkg::PROD_W-1]}}, prod_q}
               + {{(lcmlt_pkg::VAL_W-lcmlt_pkg::ICPT_W){req_i.b[lcmlt_pkg::ICPT_W-1]}}, req_i.b};

endmodule
`default_nettype wire
